[src/ptg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ptg_pkg;

   // Number of slots that the register layout can describe.
   localparam int unsigned MAX_SLOTS = 4;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned PHASE_W = 2;
   localparam int unsigned MODE_W  = 2;

   // Timer phases.
   localparam logic [PHASE_W-1:0] PH_NOT_STARTED = 2'd0;
   localparam logic [PHASE_W-1:0] PH_RUNNING     = 2'd1;
   localparam logic [PHASE_W-1:0] PH_EXPIRED     = 2'd2;

   // Timer modes; the unused code behaves as one-shot.
   localparam logic [MODE_W-1:0] MODE_ONE_SHOT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REPEATING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FINITE    = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMER_COUNT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DURATIONS_LOW  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DURATIONS_HIGH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMER_MODES    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALL_LIMITS    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTION_MASK    = 3'd5;

   typedef struct packed {
      logic [TIME_W-1:0]  duration;
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] limit;
      logic               has_action;
   } slot_cfg_type;

   typedef struct packed {
      logic fire;
      logic late;
      logic expired;
   } slot_flags_type;

endpackage

`default_nettype wire

[src/ptg_slot.sv]
`timescale 1ns / 1ps
`default_nettype none

module ptg_slot
   import ptg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              active,
   input  wire logic [TIME_W-1:0] now_ms,
   input  wire logic [TIME_W-1:0] tick_gap,
   input  wire slot_cfg_type      cfg,
   output slot_flags_type         flags
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TIME_W-1:0]  last_fire_ff, last_fire_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               starting;
   logic [PHASE_W-1:0] run_phase;
   logic [TIME_W-1:0]  base;
   logic [TIME_W-1:0]  deadline;
   logic [TIME_W-1:0]  late_deadline;
   logic [COUNT_W-1:0] count_inc;
   logic               due;
   logic               repeats;
   logic               late;

   // A slot that is not yet started starts on this tick with the tick's time.
   assign starting      = active && (phase_ff == PH_NOT_STARTED);
   assign run_phase     = starting ? PH_RUNNING : phase_ff;
   assign base          = starting ? now_ms : last_fire_ff;
   assign deadline      = base + cfg.duration;
   assign late_deadline = base + {cfg.duration[TIME_W-2:0], 1'b0};
   assign count_inc     = count_ff + COUNT_W'(1);
   assign due           = active && (run_phase == PH_RUNNING) && (now_ms >= deadline);
   assign repeats       = (cfg.mode == MODE_REPEATING) || (cfg.mode == MODE_FINITE);

   always_comb begin
      phase_in     = run_phase;
      last_fire_in = base;
      count_in     = count_ff;
      // Group overrun: the tick gap exceeds this active slot's duration.
      late         = active && (tick_gap > cfg.duration);
      if (due) begin
         if (repeats) begin
            if (now_ms > late_deadline) begin
               late = 1'b1;
            end
            last_fire_in = now_ms;
         end else begin
            phase_in = PH_EXPIRED;
         end
         if (cfg.mode == MODE_FINITE) begin
            count_in = count_inc;
            if (count_inc >= cfg.limit) begin
               phase_in = PH_EXPIRED;
            end
         end
         if (!cfg.has_action) begin
            late = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NOT_STARTED;
         last_fire_ff <= '0;
         count_ff     <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         last_fire_ff <= last_fire_in;
         count_ff     <= count_in;
      end
   end

   assign flags.fire    = due;
   assign flags.late    = late;
   assign flags.expired = (phase_in == PH_EXPIRED);

endmodule

`default_nettype wire

[src/periodic_timer_group_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Group of up to four millisecond timers, each one-shot, repeating or finite-use.
// The req channel carries one time stamp per tick (req_now_ms); the rsp channel
// returns one item per tick: the timers that fired, the timers now expired, and
// an on-time flag that drops on overrun, a missed period or a fire without action.
// Both channels use valid and stall; an item moves when valid is high and stall
// is low. The csr channel writes the six configuration registers by index and is
// always ready; writes are to be made while no tick is in flight and apply to the
// next; the block itself does not enforce this. A tick in the input register
// is evaluated by all slots in parallel and moves on into the result register,
// which shows it. Throughput is one tick per cycle while the receiver does not
// stall; the per-slot compare and update logic between the registers sets it.
// When the receiver stalls, the result register holds its item, the input
// register holds the next tick, and req_stall rises only when both are full.
// Reset clears both valid flags, the configuration to its reset values (action
// mask all ones), every slot to not started, and the last tick time to zero.
module periodic_timer_group_unit
   import ptg_pkg::*;
#(
   parameter int unsigned TIMER_SLOTS = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [TIME_W-1:0]      req_now_ms,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [MAX_SLOTS-1:0]        rsp_fire_mask,
   output logic [MAX_SLOTS-1:0]        rsp_expired_mask,
   output logic                        rsp_on_time,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]            csr_data
);

   // Configuration registers.
   logic [2:0]                   timer_count_ff;
   logic [2*MAX_SLOTS*TIME_W/2-1:0] durations_ff;
   logic [MAX_SLOTS*MODE_W-1:0]  timer_modes_ff;
   logic [MAX_SLOTS*COUNT_W-1:0] call_limits_ff;
   logic [MAX_SLOTS-1:0]         action_mask_ff;

   // Input register.
   logic                         in_valid_ff;
   logic [TIME_W-1:0]            now_ff;

   // Result register.
   logic                         out_valid_ff;
   logic [MAX_SLOTS-1:0]         fire_ff, fire_in;
   logic [MAX_SLOTS-1:0]         expired_ff, expired_in;
   logic                         on_time_ff, on_time_in;

   logic [TIME_W-1:0]            last_tick_ff;
   logic [TIME_W-1:0]            tick_gap;
   logic [MAX_SLOTS-1:0]         late_vec;
   logic                         advance;
   logic                         accept;

   // The tick in the input register moves on whenever the result register is
   // empty or is being emptied in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign tick_gap  = now_ff - last_tick_ff;

   genvar g;
   generate
      for (g = 0; g < MAX_SLOTS; g++) begin : gen_slot
         if (g < TIMER_SLOTS) begin : gen_used
            slot_cfg_type   slot_cfg;
            slot_flags_type slot_flags;
            logic           slot_active;

            assign slot_cfg.duration   = durations_ff[g*TIME_W +: TIME_W];
            assign slot_cfg.mode       = timer_modes_ff[g*MODE_W +: MODE_W];
            assign slot_cfg.limit      = call_limits_ff[g*COUNT_W +: COUNT_W];
            assign slot_cfg.has_action = action_mask_ff[g];
            assign slot_active         = (timer_count_ff > 3'(g));

            ptg_slot u_slot (
               .clock    (clock),
               .reset    (reset),
               .advance  (advance),
               .active   (slot_active),
               .now_ms   (now_ff),
               .tick_gap (tick_gap),
               .cfg      (slot_cfg),
               .flags    (slot_flags)
            );

            assign fire_in[g]    = slot_flags.fire;
            assign expired_in[g] = slot_flags.expired;
            assign late_vec[g]   = slot_flags.late;
         end else begin : gen_unused
            // Slots beyond the built ones never start, fire or expire.
            assign fire_in[g]    = 1'b0;
            assign expired_in[g] = 1'b0;
            assign late_vec[g]   = 1'b0;
         end
      end
   endgenerate

   assign on_time_in = ~|late_vec;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_count_ff <= '0;
         durations_ff   <= '0;
         timer_modes_ff <= '0;
         call_limits_ff <= '0;
         action_mask_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIMER_COUNT:    timer_count_ff <= csr_data[2:0];
            CSR_DURATIONS_LOW:  durations_ff[2*TIME_W-1:0] <= csr_data;
            CSR_DURATIONS_HIGH: durations_ff[4*TIME_W-1:2*TIME_W] <= csr_data;
            CSR_TIMER_MODES:    timer_modes_ff <= csr_data[MAX_SLOTS*MODE_W-1:0];
            CSR_CALL_LIMITS:    call_limits_ff <= csr_data[MAX_SLOTS*COUNT_W-1:0];
            CSR_ACTION_MASK:    action_mask_ff <= csr_data[MAX_SLOTS-1:0];
            default: ;
         endcase
      end
   end

   // Input register and last tick time.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         last_tick_ff <= '0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            last_tick_ff <= now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff <= req_now_ms;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fire_ff    <= fire_in;
         expired_ff <= expired_in;
         on_time_ff <= on_time_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_fire_mask    = fire_ff;
   assign rsp_expired_mask = expired_ff;
   assign rsp_on_time      = on_time_ff;

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

// The bench drives the timer group with millisecond time stamps and checks
// every result item against its own predictor of the group.
module tb_top;
   import ptg_pkg::*;

   // The spare mode code has no name in the package; the group treats it as one-shot.
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   // Index 7 addresses no register, so a write to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REGISTER = 3'd7;

   // One result item of the group, as the predictor works it out.
   typedef struct packed {
      logic [MAX_SLOTS-1:0] fire_mask;
      logic [MAX_SLOTS-1:0] expired_mask;
      logic                 on_time;
   } tick_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [TIME_W-1:0]      req_now_ms = '0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [MAX_SLOTS-1:0]   rsp_fire_mask;
   logic [MAX_SLOTS-1:0]   rsp_expired_mask;
   logic                   rsp_on_time;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]            csr_data = '0;

   // Time stamps waiting to be sent, and the results still owed by the group.
   logic [TIME_W-1:0] stamps_to_send[$];
   tick_result_type   tick_results_due[$];

   int unsigned failures = 0;
   // While set, neither side inserts gaps, so the block runs at full rate.
   bit          quiet = 1'b0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   tick_result_type due_result;

   // Predictor copy of the configuration registers, at their reset values.
   logic [2:0]  cfg_count   = '0;
   logic [63:0] cfg_dur_lo  = '0;
   logic [63:0] cfg_dur_hi  = '0;
   logic [7:0]  cfg_modes   = '0;
   logic [63:0] cfg_limits  = '0;
   logic [3:0]  cfg_actions = 4'hF;

   // Predictor copy of the timer state; every slot starts out not started.
   logic [PHASE_W-1:0] slot_phase[MAX_SLOTS] = '{default: PH_NOT_STARTED};
   logic [TIME_W-1:0]  slot_last_fire[MAX_SLOTS] = '{default: '0};
   logic [COUNT_W-1:0] slot_fires[MAX_SLOTS] = '{default: '0};
   logic [TIME_W-1:0]  prev_stamp = '0;

   periodic_timer_group_unit #(
      .TIMER_SLOTS(4)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_fire_mask(rsp_fire_mask),
      .rsp_expired_mask(rsp_expired_mask),
      .rsp_on_time(rsp_on_time),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // Gap lengths for both sides: mostly none, sometimes a few cycles, rarely a long pause.
   function automatic int unsigned draw_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Durations cluster near the tick spacing so that fires, missed periods and
   // overruns all happen; zero, all ones and fully random values show up too.
   function automatic logic [31:0] pick_duration();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 32'd0;
      if (roll == 1) return $urandom();
      if (roll == 2) return 32'hFFFF_FFFF;
      return $urandom_range(1, 50);
   endfunction

   function automatic logic [31:0] slot_duration(input int idx);
      logic [63:0] pair;
      pair = (idx < 2) ? cfg_dur_lo : cfg_dur_hi;
      return pair[32 * (idx % 2) +: 32];
   endfunction

   // Advances the predicted timer state by one tick and returns the result item
   // the group owes for it. All sums wrap at 32 bits and compares are unsigned.
   function automatic tick_result_type timer_group_tick(input logic [TIME_W-1:0] stamp);
      tick_result_type    res;
      int                 active;
      logic [31:0]        min_dur;
      logic [31:0]        dur;
      logic [31:0]        since_prev;
      logic [31:0]        due_at;
      logic [31:0]        late_at;
      logic [MODE_W-1:0]  mode;
      res.fire_mask = '0;
      res.expired_mask = '0;
      res.on_time = 1'b1;
      active = (cfg_count > MAX_SLOTS) ? MAX_SLOTS : cfg_count;
      if (active > 0) begin
         min_dur = slot_duration(0);
         for (int i = 1; i < active; i++) begin
            if (slot_duration(i) < min_dur) min_dur = slot_duration(i);
         end
         since_prev = stamp - prev_stamp;
         if (since_prev > min_dur) res.on_time = 1'b0;
         for (int i = 0; i < active; i++) begin
            dur = slot_duration(i);
            mode = cfg_modes[2 * i +: 2];
            if (slot_phase[i] == PH_NOT_STARTED) begin
               slot_phase[i] = PH_RUNNING;
               slot_last_fire[i] = stamp;
            end
            due_at = slot_last_fire[i] + dur;
            if (slot_phase[i] == PH_RUNNING && stamp >= due_at) begin
               res.fire_mask[i] = 1'b1;
               if (mode == MODE_REPEATING || mode == MODE_FINITE) begin
                  late_at = slot_last_fire[i] + (dur << 1);
                  if (stamp > late_at) res.on_time = 1'b0;
                  slot_last_fire[i] = stamp;
               end else begin
                  slot_phase[i] = PH_EXPIRED;
               end
               if (mode == MODE_FINITE) begin
                  slot_fires[i] = slot_fires[i] + 1'b1;
                  if (slot_fires[i] >= cfg_limits[16 * i +: 16]) slot_phase[i] = PH_EXPIRED;
               end
               if (!cfg_actions[i]) res.on_time = 1'b0;
            end
         end
      end
      prev_stamp = stamp;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (slot_phase[i] == PH_EXPIRED) res.expired_mask[i] = 1'b1;
      end
      return res;
   endfunction

   // Sender. A tick is predicted at the edge where the group takes it, so the
   // expected result is queued in the same order in which the ticks go in.
   // The payload only changes when no item is held by a stall.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            tick_results_due = {tick_results_due, timer_group_tick(req_now_ms)};
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (stamps_to_send.size() > 0) begin
               req_valid <= 1'b1;
               req_now_ms <= stamps_to_send.pop_front();
               send_gap = draw_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Each result item taken is checked field by field against the
   // oldest expectation; the stall pattern runs independently of the traffic.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (tick_results_due.size() == 0) begin
               $error("result item arrived with no tick outstanding");
               failures++;
            end else begin
               due_result = tick_results_due.pop_front();
               if (rsp_fire_mask !== due_result.fire_mask) begin
                  $error("fire_mask: expected %h, got %h", due_result.fire_mask, rsp_fire_mask);
                  failures++;
               end
               if (rsp_expired_mask !== due_result.expired_mask) begin
                  $error("expired_mask: expected %h, got %h",
                         due_result.expired_mask, rsp_expired_mask);
                  failures++;
               end
               if (rsp_on_time !== due_result.on_time) begin
                  $error("on_time: expected %b, got %b", due_result.on_time, rsp_on_time);
                  failures++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = draw_gap();
         end
      end
   end

   // Starts one register write at the current rising edge and returns at the edge
   // where it is taken. Valid stays high so that writes can follow back to back;
   // close_writes lowers it once the batch is done.
   task automatic set_register(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TIMER_COUNT:    cfg_count = value[2:0];
         CSR_DURATIONS_LOW:  cfg_dur_lo = value;
         CSR_DURATIONS_HIGH: cfg_dur_hi = value;
         CSR_TIMER_MODES:    cfg_modes = value[7:0];
         CSR_CALL_LIMITS:    cfg_limits = value;
         CSR_ACTION_MASK:    cfg_actions = value[3:0];
         default: ;
      endcase
   endtask

   task automatic close_writes();
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // The test holds off until every tick has been sent and answered. Polling
   // on the falling edge keeps clear of the updates made at the rising edge.
   task automatic drain_all();
      while (stamps_to_send.size() != 0 || req_valid || tick_results_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Ends the run if the traffic stops; this is several times the slowest
   // correct run with every item meeting the longest gaps and stalls.
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [31:0] wall_ms;
      logic [63:0] junk;
      logic [2:0]  count;
      logic [3:0]  actions;
      logic [MODE_W-1:0]  mode0;
      logic [MODE_W-1:0]  mode1;
      logic [COUNT_W-1:0] limit0;
      logic [COUNT_W-1:0] limit1;
      int unsigned pick;
      bit          ending;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // With no timers in the group nothing fires, nothing is late, and only the
      // last tick time moves; the time stamps cover both extremes.
      stamps_to_send = '{32'd0, 32'hFFFF_FFFF, 32'd5};
      drain_all();

      // Two active slots: slot 0 repeats with zero duration and has no action,
      // so it fires on every tick including its start; slot 1 is finite-use with
      // the largest limit. Slots 2 and 3 are configured but stay inactive.
      @(posedge clock);
      set_register(CSR_NO_REGISTER, '1);
      set_register(CSR_TIMER_COUNT, 64'd2);
      set_register(CSR_DURATIONS_LOW, {32'd20, 32'd0});
      set_register(CSR_DURATIONS_HIGH, {32'hFFFF_FFFF, 32'd0});
      set_register(CSR_TIMER_MODES,
                   {56'd0, MODE_SPARE, MODE_FINITE, MODE_FINITE, MODE_REPEATING});
      set_register(CSR_CALL_LIMITS, {16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF});
      set_register(CSR_ACTION_MASK, 64'b1110);
      close_writes();
      stamps_to_send = '{32'd100, 32'd100, 32'd110, 32'd120, 32'd135, 32'd200, 32'd201};
      drain_all();

      // A count above the slot number activates all four. Slot 2 is finite-use
      // with a zero limit and zero duration, so it fires and expires at once.
      // Slot 3 uses the spare mode with an all-ones duration: its due time wraps
      // to just before its start, so it fires once as a one-shot and expires.
      // The stamps then wrap through zero.
      @(posedge clock);
      set_register(CSR_TIMER_COUNT, 64'd7);
      set_register(CSR_DURATIONS_LOW, {32'd20, 32'd5});
      set_register(CSR_ACTION_MASK, 64'hF);
      close_writes();
      stamps_to_send = '{32'd210, 32'd211, 32'hFFFF_FFFF, 32'd3, 32'd8, 32'd40};
      drain_all();

      // Random phases. Slots 0 and 1 keep running as repeating or finite-use
      // timers with limits they cannot reach, until the last phases give slot 1
      // any mode and a small limit so that it expires. Narrow registers get junk
      // in their unused upper bits, which the group must ignore.
      for (int phase = 0; phase < 8; phase++) begin
         ending = (phase >= 6);
         quiet = (phase == 2) || ($urandom_range(0, 4) == 0);
         junk = {$urandom(), $urandom()};
         pick = $urandom_range(0, 9);
         if (pick == 0) count = 3'd0;
         else if (pick == 1) count = 3'($urandom_range(5, 7));
         else count = 3'($urandom_range(1, 4));
         mode0 = $urandom_range(0, 1) ? MODE_FINITE : MODE_REPEATING;
         if (ending) mode1 = 2'($urandom_range(0, 3));
         else mode1 = $urandom_range(0, 1) ? MODE_FINITE : MODE_REPEATING;
         limit0 = 16'($urandom_range(16'h8000, 16'hFFFF));
         limit1 = ending ? 16'($urandom_range(0, 8)) : 16'($urandom_range(16'h8000, 16'hFFFF));
         actions = ($urandom_range(0, 9) < 7) ? 4'hF : 4'($urandom_range(0, 15));

         @(posedge clock);
         set_register(CSR_TIMER_COUNT, {junk[63:3], count});
         set_register(CSR_DURATIONS_LOW, {pick_duration(), pick_duration()});
         set_register(CSR_DURATIONS_HIGH, {pick_duration(), pick_duration()});
         set_register(CSR_TIMER_MODES, {junk[63:8], 2'($urandom_range(0, 3)),
                                        2'($urandom_range(0, 3)), mode1, mode0});
         set_register(CSR_CALL_LIMITS, {32'($urandom()), limit1, limit0});
         set_register(CSR_ACTION_MASK, {junk[63:4], actions});
         close_writes();

         // Time mostly moves forward by about a duration; sometimes it stands
         // still, jumps anywhere, or steps back. Some phases start just short
         // of the wrap so that the due times wrap too.
         wall_ms = prev_stamp;
         if ($urandom_range(0, 2) == 0) wall_ms = 32'hFFFF_FF00 + $urandom_range(0, 200);
         for (int k = 0; k < 200; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) wall_ms = wall_ms + $urandom_range(0, 60);
            else if (pick < 88) wall_ms = wall_ms + $urandom_range(0, 3);
            else if (pick < 95) wall_ms = $urandom();
            else wall_ms = wall_ms - $urandom_range(1, 100);
            stamps_to_send = {stamps_to_send, wall_ms};
         end
         drain_all();
      end

      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
src/ptg_pkg.sv
src/ptg_slot.sv
src/periodic_timer_group_unit.sv
sim/tb_top.sv
